// ===== hdl/lmf_pkg.sv =====
`timescale 1ns / 1ps
// lmf_pkg: shared widths, types and default parameters of the label majority filter
// no dependencies; imported by lmf_line_store, lmf_vote and the top level
package lmf_pkg;

    localparam int LabelW        = 4;
    localparam int CoordW        = 6;
    localparam int CountW        = 4;
    localparam int ClassMax      = 16;
    localparam int BankW         = 2;
    localparam int DefGridSide   = 16;
    localparam int DefClassCount = 4;

    localparam logic [LabelW-1:0] UnknownRst = 4'd3;

    typedef logic [LabelW-1:0] t_label;
    typedef logic [CoordW-1:0] t_coord;
    typedef logic [CountW-1:0] t_count;

endpackage

// ===== hdl/lmf_line_store.sv =====
`timescale 1ns / 1ps
// lmf_line_store: three-row label store, one write port and one read port
// read data registered; depends on lmf_pkg
module lmf_line_store
    import lmf_pkg::*;
#(
    parameter int GRID_SIDE = DefGridSide
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(3*GRID_SIDE)-1:0]      i_waddr,
    input  t_label                              i_wdata,
    input  logic                                i_re,
    input  logic [$clog2(3*GRID_SIDE)-1:0]      i_raddr,
    output t_label                              o_rdata
);

    localparam int Depth = 3 * GRID_SIDE;

    t_label mem [Depth];
    t_label r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lmf_vote.sv =====
`timescale 1ns / 1ps
// lmf_vote: class histogram of a 3x3 window, registered maximum and tie-aware pick
// two register stages (counts, maximum); depends on lmf_pkg
module lmf_vote
    import lmf_pkg::*;
#(
    parameter int CLASS_COUNT = DefClassCount
) (
    input  logic   i_clk,
    input  logic   i_load,
    input  t_label i_win [9],
    input  t_label i_center,
    input  t_label i_unknown,
    output t_label o_label
);

    localparam logic [LabelW:0] ClassLim = (LabelW+1)'(CLASS_COUNT);

    t_count counts [ClassMax];
    t_label start;
    t_count r_counts [ClassMax];
    t_label r_start;
    t_count r_max;
    t_count m8 [8];
    t_count m4 [4];
    t_count m2 [2];
    t_count max_all;

    // per-class count, classes at or above the class count stay zero
    always_comb begin
        for (int cls = 0; cls < ClassMax; cls++) begin
            counts[cls] = '0;
            if (cls < CLASS_COUNT) begin
                for (int j = 0; j < 9; j++) begin
                    counts[cls] = counts[cls] + CountW'(i_win[j] == LabelW'(cls));
                end
            end
        end
        start = ({1'b0, i_center} < ClassLim) ? i_center : i_unknown;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_counts <= counts;
            r_start  <= start;
        end
    end

    // maximum tree over the registered counts
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            m8[i] = (r_counts[2*i] > r_counts[2*i+1]) ? r_counts[2*i] : r_counts[2*i+1];
        end
        for (int i = 0; i < 4; i++) begin
            m4[i] = (m8[2*i] > m8[2*i+1]) ? m8[2*i] : m8[2*i+1];
        end
        for (int i = 0; i < 2; i++) begin
            m2[i] = (m4[2*i] > m4[2*i+1]) ? m4[2*i] : m4[2*i+1];
        end
        max_all = (m2[0] > m2[1]) ? m2[0] : m2[1];
    end

    always_ff @(posedge i_clk) begin
        r_max <= max_all;
    end

    // keep the start class when it reaches the maximum, else lowest class at the maximum
    always_comb begin
        o_label = r_start;
        if (r_counts[r_start] != r_max) begin
            for (int i = ClassMax - 1; i >= 0; i--) begin
                if (r_counts[i] == r_max) begin
                    o_label = LabelW'(i);
                end
            end
        end
    end

endmodule

// ===== hdl/label_majority_filter_3x3_unit.sv =====
`timescale 1ns / 1ps
// label_majority_filter_3x3_unit: 3x3 mode filter over a raster of class labels
// input flow: no new input is taken while a run of results is in progress; the pace of
//   results is set by the single read port of the line store (three reads per result,
//   six in column 0) and the vote stages
// reset: synchronous active low; clears position, sequencer, output valid, unknown class to 3
// depends on lmf_pkg, lmf_line_store, lmf_vote
module label_majority_filter_3x3_unit
    import lmf_pkg::*;
#(
    parameter int GRID_SIDE   = DefGridSide,
    parameter int CLASS_COUNT = DefClassCount
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    // label input channel
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_label i_label_in,
    // result channel
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_label o_label_out,
    output t_coord o_cell_col,
    output t_coord o_cell_row,
    output logic   o_run_last,
    output logic   o_frame_last,
    // configuration write channel (unknown class)
    input  logic   i_cfg_valid,
    output logic   o_cfg_ready,
    input  t_label i_cfg_data
);

    localparam int     AddrW = $clog2(3 * GRID_SIDE);
    localparam int     LeftW = $clog2(GRID_SIDE + 3);
    localparam t_coord Last  = CoordW'(GRID_SIDE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TAIL,
        S_COUNT,
        S_MAX,
        S_PICK
    } t_state;

    // bank arithmetic, row r lives in bank r mod 3
    function automatic logic [BankW-1:0] bank_inc(input logic [BankW-1:0] b);
        return (b == 2'd2) ? 2'd0 : b + 2'd1;
    endfunction

    function automatic logic [BankW-1:0] bank_dec(input logic [BankW-1:0] b);
        return (b == 2'd0) ? 2'd2 : b - 2'd1;
    endfunction

    function automatic logic [AddrW-1:0] bank_base(input logic [BankW-1:0] b);
        logic [AddrW-1:0] base;
        unique case (b)
            2'd0:    base = '0;
            2'd1:    base = AddrW'(GRID_SIDE);
            default: base = AddrW'(2 * GRID_SIDE);
        endcase
        return base;
    endfunction

    t_state            r_state;
    t_label            r_unknown;
    // position and bank of the next input cell
    t_coord            r_in_col;
    t_coord            r_in_row;
    logic [BankW-1:0]  r_in_bank;
    // cell being filtered
    t_coord            r_ec;
    t_coord            r_er;
    logic [BankW-1:0]  r_ebank;
    logic [LeftW-1:0]  r_left;
    logic              r_full;
    // read issue counters and their registered copies for capture
    logic [1:0]        r_rrow;
    logic              r_rcol2;
    logic              r_cv;
    logic [1:0]        r_crow;
    logic              r_ccol2;
    // 3x3 window, [column][row]: column 0 left, row 0 above
    t_label            r_win [3][3];
    // result register
    logic              r_ov;
    t_label            r_label;
    t_coord            r_col;
    t_coord            r_row;
    logic              r_rl;
    logic              r_fl;

    logic              in_xfer;
    logic              out_free;
    logic              out_load;
    logic              mem_we;
    logic              mem_re;
    logic [AddrW-1:0]  waddr;
    logic [AddrW-1:0]  raddr;
    t_label            rdata;
    t_coord            col_ahead;
    t_coord            rd_col;
    logic [BankW-1:0]  rd_bank;
    t_label            vote_win [9];
    t_label            vote_label;
    logic              vote_load;
    logic              acc_emit;
    logic [LeftW-1:0]  acc_left;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    // result register frees at this edge when empty or being taken
    assign out_free    = !r_ov || !i_out_stall;
    // a new result enters the result register at this edge
    assign out_load    = (r_state == S_PICK) && out_free;

    // input write happens at the transfer edge; reads only in S_READ, so never the same cycle
    assign mem_we = in_xfer;
    assign mem_re = (r_state == S_READ);
    assign waddr  = bank_base(r_in_bank) + AddrW'(r_in_col);

    assign col_ahead = (r_ec == Last) ? Last : r_ec + CoordW'(1);

    always_comb begin
        if (r_rcol2) begin
            rd_col = CoordW'(1);
        end else if (r_full) begin
            rd_col = '0;
        end else begin
            rd_col = col_ahead;
        end
        // replicate the top and bottom rows at the border
        unique case (r_rrow)
            2'd0:    rd_bank = (r_er == '0) ? r_ebank : bank_dec(r_ebank);
            2'd2:    rd_bank = (r_er == Last) ? r_ebank : bank_inc(r_ebank);
            default: rd_bank = r_ebank;
        endcase
    end

    assign raddr = bank_base(rd_bank) + AddrW'(rd_col);

    lmf_line_store #(
        .GRID_SIDE (GRID_SIDE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (i_label_in),
        .i_re    (mem_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                vote_win[c*3+r] = r_win[c][r];
            end
        end
    end

    assign vote_load = (r_state == S_COUNT);

    lmf_vote #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_vote (
        .i_clk     (i_clk),
        .i_load    (vote_load),
        .i_win     (vote_win),
        .i_center  (r_win[1][1]),
        .i_unknown (r_unknown),
        .o_label   (vote_label)
    );

    // an input at row >= 1 and column >= 1 starts a run of results in raster order:
    // the cell up-left, the right edge cell when at the last column, and the whole
    // bottom row after the final input of the frame
    assign acc_emit = (r_in_row != '0) && (r_in_col != '0);
    always_comb begin
        acc_left = LeftW'(1);
        if (r_in_col == Last) begin
            acc_left = acc_left + LeftW'(1);
            if (r_in_row == Last) begin
                acc_left = acc_left + LeftW'(GRID_SIDE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_unknown <= UnknownRst;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_bank <= '0;
            r_left    <= '0;
            r_cv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_unknown <= i_cfg_data;
            end

            // capture read data in the cycle after it is issued
            r_cv    <= mem_re;
            r_crow  <= r_rrow;
            r_ccol2 <= r_rcol2;
            if (r_cv) begin
                if (!r_ccol2 && r_full) begin
                    // column 0: the left neighbor replicates the center column
                    r_win[0][r_crow] <= rdata;
                    r_win[1][r_crow] <= rdata;
                end else begin
                    r_win[2][r_crow] <= rdata;
                end
            end

            // result valid: set on a new result, else cleared once taken
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (r_in_col == Last) begin
                            r_in_col  <= '0;
                            r_in_row  <= (r_in_row == Last) ? '0 : r_in_row + CoordW'(1);
                            r_in_bank <= (r_in_row == Last) ? '0 : bank_inc(r_in_bank);
                        end else begin
                            r_in_col <= r_in_col + CoordW'(1);
                        end
                        if (acc_emit) begin
                            r_er    <= r_in_row - CoordW'(1);
                            r_ec    <= r_in_col - CoordW'(1);
                            r_ebank <= bank_dec(r_in_bank);
                            r_left  <= acc_left;
                            r_full  <= (r_in_col == CoordW'(1));
                            r_rrow  <= '0;
                            r_rcol2 <= 1'b0;
                            // slide the window: previous result was the cell to the left
                            if (r_in_col != CoordW'(1)) begin
                                r_win[0] <= r_win[1];
                                r_win[1] <= r_win[2];
                            end
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_rrow == 2'd2) begin
                        r_rrow <= '0;
                        if (r_full && !r_rcol2) begin
                            r_rcol2 <= 1'b1;
                        end else begin
                            r_state <= S_TAIL;
                        end
                    end else begin
                        r_rrow <= r_rrow + 2'd1;
                    end
                end
                S_TAIL: begin
                    r_state <= S_COUNT;
                end
                S_COUNT: begin
                    r_state <= S_MAX;
                end
                S_MAX: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (out_free) begin
                        r_label <= vote_label;
                        r_col   <= r_ec;
                        r_row   <= r_er;
                        r_rl    <= (r_left == LeftW'(1));
                        r_fl    <= (r_er == Last) && (r_ec == Last);
                        r_left  <= r_left - LeftW'(1);
                        if (r_left == LeftW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rrow  <= '0;
                            r_rcol2 <= 1'b0;
                            if (r_ec == Last) begin
                                r_ec    <= '0;
                                r_er    <= r_er + CoordW'(1);
                                r_ebank <= bank_inc(r_ebank);
                                r_full  <= 1'b1;
                            end else begin
                                r_ec     <= r_ec + CoordW'(1);
                                r_full   <= 1'b0;
                                r_win[0] <= r_win[1];
                                r_win[1] <= r_win[2];
                            end
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_label_out  = r_label;
    assign o_cell_col   = r_col;
    assign o_cell_row   = r_row;
    assign o_run_last   = r_rl;
    assign o_frame_last = r_fl;

    // a run in progress always has a result left to emit
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_left != '0))
        else $error("sequencer busy with no result left");

    // the final cell of the frame closes the run of the last input
    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_last) |-> o_run_last)
        else $error("frame end without run end");

    // store write and read never share a cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !mem_re)
        else $error("line store write and read in the same cycle");

    // input position stays on the grid and its bank is a valid row mod 3
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_in_col <= Last) && (r_in_row <= Last)
                                 && (r_in_bank != 2'd3)))
        else $error("input position out of range");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> (r_ov && $stable(r_label) && $stable(r_col)
                                   && $stable(r_row)))
        else $error("pending result overwritten");

endmodule
